// File: hdl/rlgu_pkg.sv
// ============================================================================
// Regression loss gradient unit: shared definitions
// Data formats, loss mode and register codes, exponential constants and the
// result type shared by the exponential unit, the wide multiplier and the top.
// ============================================================================
package rlgu_pkg;

   // Data format: signed Q16.16 on a 32-bit word
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Loss modes
   localparam logic [2:0] MODE_SQUARED  = 3'd0;
   localparam logic [2:0] MODE_ABSOLUTE = 3'd1;
   localparam logic [2:0] MODE_HUBER    = 3'd2;
   localparam logic [2:0] MODE_QUANTILE = 3'd3;
   localparam logic [2:0] MODE_POISSON  = 3'd4;
   localparam logic [2:0] MODE_TWEEDIE  = 3'd5;

   // Register indexes (word address)
   localparam logic [1:0] REG_LOSS_MODE      = 2'd0;
   localparam logic [1:0] REG_HUBER_DELTA    = 2'd1;
   localparam logic [1:0] REG_QUANTILE_ALPHA = 2'd2;
   localparam logic [1:0] REG_TWEEDIE_POWER  = 2'd3;

   // Register reset values
   localparam logic [2:0]  RST_LOSS_MODE      = MODE_SQUARED;
   localparam logic [30:0] RST_HUBER_DELTA    = 31'd65536;
   localparam logic [15:0] RST_QUANTILE_ALPHA = 16'd32768;
   localparam logic [16:0] RST_TWEEDIE_POWER  = 17'd98304;

   // 1.0 and 2.0 in Q16.16
   localparam logic signed [33:0] ONE_Q = 34'sd65536;
   localparam logic signed [18:0] ONE_C = 19'sd65536;
   localparam logic signed [18:0] TWO_C = 19'sd131072;

   // Exponential: argument clamp, ln2 in Q30, reciprocal estimate of k
   localparam logic signed [33:0] EXP_ARG_MAX  = 34'sd8388608;
   localparam logic signed [25:0] EXP_HALF_ARG = 26'sd22713;
   localparam logic signed [19:0] EXP_RECIP    = 20'sd94548;
   localparam logic signed [39:0] LN2_Q30      = 40'sd744261118;
   localparam logic signed [39:0] HALF_LN2_Q30 = 40'sd372130559;
   localparam int EXP_SHIFT    = 14;
   localparam int EXP_TERMS    = 7;
   localparam int EXP_LATENCY  = EXP_TERMS + 3;
   localparam int WMUL_LATENCY = 2;

   // 64-bit limits
   localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

   // Value with overflow mark
   typedef struct packed {
      logic signed [63:0] value;
      logic               ov;
   } qval_type;

   // Taylor coefficients of e^r in Q30, highest order first
   function automatic logic signed [32:0] exp_coef(input int idx);
      logic signed [32:0] c;
      case (idx)
         0:       c = 33'sd213043;
         1:       c = 33'sd1491308;
         2:       c = 33'sd8947849;
         3:       c = 33'sd44739243;
         4:       c = 33'sd178956971;
         5:       c = 33'sd536870912;
         6:       c = 33'sd1073741824;
         default: c = 33'sd1073741824;
      endcase
      return c;
   endfunction

endpackage

// File: hdl/regression_loss_gradient_unit.sv
// ============================================================================
// Regression loss gradient unit
// Gradient and hessian of a configured regression loss for one prediction and
// label pair in signed Q16.16, with saturation and label checks.
// ============================================================================
//  Port group | Direction | Carries
//  req_*      | in        | prediction [31:0], label [63:32]
//  rsp_*      | out       | gradient [31:0], hessian [63:32]; tuser bad_label, saturated
//  csr_*      | in/out    | loss_mode, huber_delta, quantile_alpha, tweedie_power
//
// One item enters per cycle unless a stalled output holds it; a result passes through
// the exponential pipeline (two steps of range reduction, seven Horner multiply
// stages, one scaling stage) and the two-stage wide multipliers.
// Reset clears valid bits and the registers; no clearing pass is needed.
// A stalled output register holds the whole pipeline; nothing is lost.
// ============================================================================
module regression_loss_gradient_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // prediction [31:0], label [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // gradient [31:0], hessian [63:32]
   output logic [1:0]  rsp_tuser,   // bad_label [0], saturated [1]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LAT = rlgu_pkg::EXP_LATENCY;
   localparam int WL  = rlgu_pkg::WMUL_LATENCY;

   typedef struct packed {
      logic signed [31:0] label;
      logic signed [33:0] lw;
      logic signed [33:0] gs;
      logic signed [33:0] hs;
      logic               bad;
   } side_type;

   typedef struct packed {
      side_type           side;
      rlgu_pkg::qval_type e1;
      rlgu_pkg::qval_type e2;
   } post_type;

   // Saturating 64-bit add and subtract, overflow in the top bit
   function automatic logic [64:0] add_sat(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         return {1'b1, s[64] ? rlgu_pkg::Q_MIN : rlgu_pkg::Q_MAX};
      end
      return {1'b0, s[63:0]};
   endfunction

   function automatic logic [64:0] sub_sat(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      if (s[64] != s[63]) begin
         return {1'b1, s[64] ? rlgu_pkg::Q_MIN : rlgu_pkg::Q_MAX};
      end
      return {1'b0, s[63:0]};
   endfunction

   // Small Q product, magnitude truncated
   function automatic logic signed [33:0] mul_small(input logic signed [18:0] a,
                                                    input logic signed [31:0] b);
      logic signed [50:0] prod;
      logic [50:0]        mag;
      logic [33:0]        shr;
      prod = 51'(a) * 51'(b);
      mag  = prod[50] ? 51'(-prod) : 51'(prod);
      shr  = mag[49:16];
      return prod[50] ? -$signed(shr) : $signed(shr);
   endfunction

   // ---------------------------------------------------------------- config
   logic [2:0]  mode_ff;
   logic [30:0] delta_ff;
   logic [15:0] alpha_ff;
   logic [16:0] power_ff;
   logic        csr_write;

   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= rlgu_pkg::RST_LOSS_MODE;
         delta_ff <= rlgu_pkg::RST_HUBER_DELTA;
         alpha_ff <= rlgu_pkg::RST_QUANTILE_ALPHA;
         power_ff <= rlgu_pkg::RST_TWEEDIE_POWER;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            rlgu_pkg::REG_LOSS_MODE:      mode_ff  <= csr_pwdata[2:0];
            rlgu_pkg::REG_HUBER_DELTA:    delta_ff <= csr_pwdata[30:0];
            rlgu_pkg::REG_QUANTILE_ALPHA: alpha_ff <= csr_pwdata[15:0];
            rlgu_pkg::REG_TWEEDIE_POWER:  power_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_paddr[3:2])
         rlgu_pkg::REG_LOSS_MODE:      csr_prdata = {29'd0, mode_ff};
         rlgu_pkg::REG_HUBER_DELTA:    csr_prdata = {1'b0, delta_ff};
         rlgu_pkg::REG_QUANTILE_ALPHA: csr_prdata = {16'd0, alpha_ff};
         rlgu_pkg::REG_TWEEDIE_POWER:  csr_prdata = {15'd0, power_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow
   logic advance;
   logic rsp_valid_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Stage 1: input register
   logic               v1_ff;
   logic signed [31:0] pred1_ff, lab1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pred1_ff <= req_tdata[31:0];
         lab1_ff  <= req_tdata[63:32];
      end
   end

   // Stage 2: Tweedie scalings and the closed-form losses
   logic signed [18:0] c1, c2, pm1;
   logic signed [33:0] m1_in, m2_in, lw_in, diff_in, gs_in, hs_in, arga_in;
   logic [32:0]        mag_in;
   logic               bad_in;

   always_comb begin
      c1      = rlgu_pkg::ONE_C - $signed({2'b00, power_ff});
      c2      = rlgu_pkg::TWO_C - $signed({2'b00, power_ff});
      pm1     = $signed({2'b00, power_ff}) - rlgu_pkg::ONE_C;
      m1_in   = mul_small(c1, pred1_ff);
      m2_in   = mul_small(c2, pred1_ff);
      lw_in   = mul_small(pm1, lab1_ff);
      diff_in = 34'(pred1_ff) - 34'(lab1_ff);
      mag_in  = diff_in[33] ? 33'(-diff_in) : diff_in[32:0];
      arga_in = (mode_ff == rlgu_pkg::MODE_TWEEDIE) ? m1_in : 34'(pred1_ff);
      bad_in  = ((mode_ff == rlgu_pkg::MODE_POISSON) ||
                 (mode_ff == rlgu_pkg::MODE_TWEEDIE)) && lab1_ff[31];
      gs_in   = '0;
      hs_in   = '0;
      unique case (mode_ff)
         rlgu_pkg::MODE_SQUARED: begin
            gs_in = diff_in;
            hs_in = rlgu_pkg::ONE_Q;
         end
         rlgu_pkg::MODE_ABSOLUTE: begin
            if (pred1_ff > lab1_ff) begin
               gs_in = rlgu_pkg::ONE_Q;
            end else if (pred1_ff < lab1_ff) begin
               gs_in = -rlgu_pkg::ONE_Q;
            end
            hs_in = rlgu_pkg::ONE_Q;
         end
         rlgu_pkg::MODE_HUBER: begin
            if (mag_in <= {2'b00, delta_ff}) begin
               gs_in = diff_in;
               hs_in = rlgu_pkg::ONE_Q;
            end else begin
               gs_in = (pred1_ff > lab1_ff) ? $signed({3'b000, delta_ff})
                                            : -$signed({3'b000, delta_ff});
            end
         end
         rlgu_pkg::MODE_QUANTILE: begin
            gs_in = (lab1_ff > pred1_ff) ? -$signed({18'd0, alpha_ff})
                                         : rlgu_pkg::ONE_Q - $signed({18'd0, alpha_ff});
            hs_in = rlgu_pkg::ONE_Q;
         end
         default: ;
      endcase
   end

   logic               v2_ff;
   logic signed [33:0] arga_ff, argb_ff;
   side_type           side2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         arga_ff        <= arga_in;
         argb_ff        <= m2_in;
         side2_ff.label <= lab1_ff;
         side2_ff.lw    <= lw_in;
         side2_ff.gs    <= gs_in;
         side2_ff.hs    <= hs_in;
         side2_ff.bad   <= bad_in;
      end
   end

   // Exponentials, with side data carried alongside
   rlgu_pkg::qval_type e1, e2;

   rlgu_exp u_exp_a (.clock(clock), .enable(advance), .arg(arga_ff), .result(e1));
   rlgu_exp u_exp_b (.clock(clock), .enable(advance), .arg(argb_ff), .result(e2));

   side_type side_pipe [0:LAT-1];
   logic     v_pipe    [0:LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            v_pipe[i] <= 1'b0;
         end
      end else if (advance) begin
         v_pipe[0] <= v2_ff;
         for (int i = 1; i < LAT; i++) begin
            v_pipe[i] <= v_pipe[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_pipe[0] <= side2_ff;
         for (int i = 1; i < LAT; i++) begin
            side_pipe[i] <= side_pipe[i-1];
         end
      end
   end

   // Wide products: label*e1, lw*e1, c2*e2
   side_type           side_x;
   logic signed [32:0] labx, lwx;
   logic [32:0]        lab_mag, lw_mag;
   rlgu_pkg::qval_type qa, qb, qc;

   always_comb begin
      side_x  = side_pipe[LAT-1];
      labx    = 33'(side_x.label);
      lab_mag = labx[32] ? 33'(-labx) : 33'(labx);
      lwx     = side_x.lw[32:0];
      lw_mag  = side_x.lw[33] ? 33'(-side_x.lw) : 33'(lwx);
   end

   rlgu_wmul u_mul_a (.clock(clock), .enable(advance), .a_mag(lab_mag),
                      .a_neg(side_x.label[31]), .b_mag(e1.value[62:0]), .result(qa));
   rlgu_wmul u_mul_b (.clock(clock), .enable(advance), .a_mag(lw_mag),
                      .a_neg(side_x.lw[33]), .b_mag(e1.value[62:0]), .result(qb));
   rlgu_wmul u_mul_c (.clock(clock), .enable(advance), .a_mag(33'(unsigned'(c2))),
                      .a_neg(1'b0), .b_mag(e2.value[62:0]), .result(qc));

   post_type post_ff [0:WL-1];
   logic     pv_ff   [0:WL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WL; i++) begin
            pv_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         pv_ff[0] <= v_pipe[LAT-1];
         for (int i = 1; i < WL; i++) begin
            pv_ff[i] <= pv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         post_ff[0] <= '{side: side_x, e1: e1, e2: e2};
         for (int i = 1; i < WL; i++) begin
            post_ff[i] <= post_ff[i-1];
         end
      end
   end

   // Stage 5: combine per mode
   post_type           pst;
   logic [64:0]        gp_in, gt_in, ht_in;
   logic signed [63:0] g5_in, h5_in;
   logic               ov5_in;

   always_comb begin
      pst   = post_ff[WL-1];
      gp_in = sub_sat(pst.e1.value, 64'(pst.side.label));
      gt_in = sub_sat(pst.e2.value, qa.value);
      ht_in = add_sat(qb.value, qc.value);
      unique case (mode_ff)
         rlgu_pkg::MODE_POISSON: begin
            g5_in  = gp_in[63:0];
            h5_in  = pst.e1.value;
            ov5_in = pst.e1.ov | gp_in[64];
         end
         rlgu_pkg::MODE_TWEEDIE: begin
            g5_in  = gt_in[63:0];
            h5_in  = ($signed(ht_in[63:0]) < 64'sd1) ? 64'sd1 : ht_in[63:0];
            ov5_in = pst.e1.ov | pst.e2.ov | qa.ov | qb.ov | qc.ov
                   | gt_in[64] | ht_in[64];
         end
         default: begin
            g5_in  = 64'(pst.side.gs);
            h5_in  = 64'(pst.side.hs);
            ov5_in = 1'b0;
         end
      endcase
   end

   logic               v5_ff, ov5_ff, bad5_ff;
   logic signed [63:0] g5_ff, h5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= pv_ff[WL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         g5_ff   <= g5_in;
         h5_ff   <= h5_in;
         ov5_ff  <= ov5_in;
         bad5_ff <= pst.side.bad;
      end
   end

   // Output: clamp to 32 bits and flag the clamp
   logic [31:0] g_out_in, h_out_in;
   logic        gsat_in, hsat_in;

   always_comb begin
      gsat_in  = (g5_ff[63:31] != {33{g5_ff[63]}});
      hsat_in  = (h5_ff[63:31] != {33{h5_ff[63]}});
      g_out_in = gsat_in ? {g5_ff[63], {31{~g5_ff[63]}}} : g5_ff[31:0];
      h_out_in = hsat_in ? {h5_ff[63], {31{~h5_ff[63]}}} : h5_ff[31:0];
   end

   logic [63:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {h_out_in, g_out_in};
         rsp_user_ff <= {gsat_in | hsat_in | ov5_ff, bad5_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: hdl/rlgu_exp.sv
// ============================================================================
// Regression loss gradient unit: pipelined exponential
// e^x for signed Q16.16 x: clamp, range reduction to r = x - k*ln2, seven
// Horner stages of a degree-7 polynomial in Q30, then scaling by 2^k.
// ============================================================================
module rlgu_exp (
   input  logic                     clock,
   input  logic                     enable,
   input  logic signed [33:0]       arg,
   output rlgu_pkg::qval_type       result
);

   logic signed [24:0] xc_in, xc_ff;
   logic signed [25:0] sum_in;
   logic signed [44:0] est_in;
   logic signed [9:0]  q0_ff;
   logic signed [39:0] xs_in, prod_in, rr_in, r_wide;
   logic signed [9:0]  k_in;
   logic signed [32:0] p_pipe [1:EXP_TERMS_L];
   logic signed [30:0] r_pipe [0:EXP_TERMS_L-1];
   logic signed [9:0]  k_pipe [0:EXP_TERMS_L];
   logic signed [10:0] s_in, n_in;
   logic [95:0]        wide_in;
   rlgu_pkg::qval_type res_in, result_ff;

   localparam int EXP_TERMS_L = rlgu_pkg::EXP_TERMS;

   // Clamp the argument and estimate k from a reciprocal product
   always_comb begin
      if (arg > rlgu_pkg::EXP_ARG_MAX) begin
         xc_in = 25'(rlgu_pkg::EXP_ARG_MAX);
      end else if (arg < -rlgu_pkg::EXP_ARG_MAX) begin
         xc_in = 25'(-rlgu_pkg::EXP_ARG_MAX);
      end else begin
         xc_in = 25'(arg);
      end
      sum_in = 26'(xc_in) + rlgu_pkg::EXP_HALF_ARG;
      est_in = 45'(sum_in) * 45'(rlgu_pkg::EXP_RECIP);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         xc_ff <= xc_in;
         q0_ff <= est_in[41:32];
      end
   end

   // Correct k by one step either way and form the remainder in Q30
   always_comb begin
      xs_in   = 40'(xc_ff) <<< EXP_SHIFT_L;
      prod_in = 40'(q0_ff) * rlgu_pkg::LN2_Q30;
      rr_in   = xs_in + rlgu_pkg::HALF_LN2_Q30 - prod_in;
      if (rr_in < 40'sd0) begin
         k_in   = q0_ff - 10'sd1;
         r_wide = rr_in - rlgu_pkg::HALF_LN2_Q30 + rlgu_pkg::LN2_Q30;
      end else if (rr_in >= rlgu_pkg::LN2_Q30) begin
         k_in   = q0_ff + 10'sd1;
         r_wide = rr_in - rlgu_pkg::HALF_LN2_Q30 - rlgu_pkg::LN2_Q30;
      end else begin
         k_in   = q0_ff;
         r_wide = rr_in - rlgu_pkg::HALF_LN2_Q30;
      end
   end

   localparam int EXP_SHIFT_L = rlgu_pkg::EXP_SHIFT;

   always_ff @(posedge clock) begin
      if (enable) begin
         r_pipe[0] <= 31'(r_wide);
         k_pipe[0] <= k_in;
      end
   end

   // Horner stages: p = c + floor(p * r / 2^30), one multiply per stage
   for (genvar j = 1; j <= EXP_TERMS_L; j++) begin : g_horner
      logic signed [32:0] src;
      logic signed [63:0] prod;
      logic signed [32:0] p_in;

      if (j == 1) begin : g_first
         assign src = rlgu_pkg::exp_coef(0);
      end else begin : g_next
         assign src = p_pipe[j-1];
      end

      always_comb begin
         prod = 64'(src) * 64'(r_pipe[j-1]);
         p_in = rlgu_pkg::exp_coef(j) + 33'(prod >>> 30);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            p_pipe[j] <= p_in;
            k_pipe[j] <= k_pipe[j-1];
         end
      end

      if (j < EXP_TERMS_L) begin : g_rpass
         always_ff @(posedge clock) begin
            if (enable) begin
               r_pipe[j] <= r_pipe[j-1];
            end
         end
      end
   end

   // Scale by 2^(k-14) into Q16.16, rounding half up, saturating high
   always_comb begin
      s_in    = 11'(k_pipe[EXP_TERMS_L]) - 11'sd14;
      n_in    = -s_in;
      wide_in = {63'd0, p_pipe[EXP_TERMS_L]} << s_in[5:0];
      res_in  = '0;
      if (!s_in[10]) begin
         if (s_in >= 11'sd62 || (|wide_in[95:63])) begin
            res_in.value = rlgu_pkg::Q_MAX;
            res_in.ov    = 1'b1;
         end else begin
            res_in.value = $signed(wide_in[63:0]);
         end
      end else if (n_in < 11'sd62) begin
         res_in.value = $signed(({31'd0, p_pipe[EXP_TERMS_L]}
                                 + (64'd1 << (n_in[5:0] - 6'd1))) >> n_in[5:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= res_in;
      end
   end

   assign result = result_ff;

endmodule

// File: hdl/rlgu_wmul.sv
// ============================================================================
// Regression loss gradient unit: wide Q multiplier
// Sign-magnitude 33 x 63 bit product over two stages, scaled by 2^-16 with
// truncation toward zero and saturated to the signed 64-bit range.
// ============================================================================
module rlgu_wmul (
   input  logic                clock,
   input  logic                enable,
   input  logic [32:0]         a_mag,
   input  logic                a_neg,
   input  logic [62:0]         b_mag,
   output rlgu_pkg::qval_type  result
);

   logic [64:0]        p0_ff;
   logic [63:0]        p1_ff;
   logic               neg_ff;
   logic [96:0]        full_in;
   logic [80:0]        q_in;
   rlgu_pkg::qval_type res_in, result_ff;

   // Partial products on the low and high halves of b
   always_ff @(posedge clock) begin
      if (enable) begin
         p0_ff  <= 65'(a_mag) * 65'(b_mag[31:0]);
         p1_ff  <= 64'(a_mag) * 64'(b_mag[62:32]);
         neg_ff <= a_neg;
      end
   end

   // Sum, scale, saturate and apply the sign
   always_comb begin
      full_in = 97'({p1_ff, 32'd0}) + 97'(p0_ff);
      q_in    = full_in[96:16];
      res_in.ov = |q_in[80:63];
      if (res_in.ov) begin
         res_in.value = neg_ff ? rlgu_pkg::Q_MIN : rlgu_pkg::Q_MAX;
      end else begin
         res_in.value = neg_ff ? -$signed(q_in[63:0]) : $signed(q_in[63:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= res_in;
      end
   end

   assign result = result_ff;

endmodule

// File: hdl/rlgu_checker.sv
// ============================================================================
// Regression loss gradient unit: port checker
// Watches the stream ports for output stability, flow control after reset
// and the sign of the hessian.
// ============================================================================
module rlgu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // Input side open whenever the output register can move
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("req_tready low with free output");

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result right after reset");

   // Hessian is never negative in any mode
   a_hess_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[63])
      else $error("negative hessian");

endmodule

bind regression_loss_gradient_unit rlgu_checker u_rlgu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: dv/testbench.sv
// ============================================================================
// Regression loss gradient unit: stream-level testbench
// Drives prediction and label pairs through every loss mode and several
// register settings. A scoreboard predicts each gradient, hessian and flag
// pair and compares it with the result stream, under random idle and stall.
// ============================================================================
module testbench;
   import rlgu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] gradient;
      logic [31:0] hessian;
      logic        bad_label;
      logic        saturated;
   } loss_result_t;

   // Predicts the loss derivatives and holds the results still owed
   class loss_scoreboard;
      logic [2:0]   mode_reg;
      logic [30:0]  delta_reg;
      logic [15:0]  alpha_reg;
      logic [16:0]  power_reg;
      loss_result_t owed_results[$];
      int           fail_count;
      int           match_count;

      function new();
         mode_reg    = RST_LOSS_MODE;
         delta_reg   = RST_HUBER_DELTA;
         alpha_reg   = RST_QUANTILE_ALPHA;
         power_reg   = RST_TWEEDIE_POWER;
         fail_count  = 0;
         match_count = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_LOSS_MODE:      mode_reg  = value[2:0];
            REG_HUBER_DELTA:    delta_reg = value[30:0];
            REG_QUANTILE_ALPHA: alpha_reg = value[15:0];
            REG_TWEEDIE_POWER:  power_reg = value[16:0];
            default: ;
         endcase
      endfunction

      // Saturating add on 64 bits
      function longint add_q(longint a, longint b, inout bit ov);
         logic signed [64:0] t;
         t = 65'(a) + 65'(b);
         if (t > 65'(Q_MAX)) begin
            ov = 1;
            return Q_MAX;
         end
         if (t < 65'(Q_MIN)) begin
            ov = 1;
            return Q_MIN;
         end
         return longint'(t);
      endfunction

      function longint sub_q(longint a, longint b, inout bit ov);
         logic signed [64:0] t;
         t = 65'(a) - 65'(b);
         if (t > 65'(Q_MAX)) begin
            ov = 1;
            return Q_MAX;
         end
         if (t < 65'(Q_MIN)) begin
            ov = 1;
            return Q_MIN;
         end
         return longint'(t);
      endfunction

      // Q product, magnitude truncated, saturating
      function longint mul_q(longint a, longint b, inout bit ov);
         logic [63:0]  ua, ub;
         logic [127:0] prod;
         bit           neg;
         ua   = (a < 0) ? 64'(-a) : 64'(a);
         ub   = (b < 0) ? 64'(-b) : 64'(b);
         prod = ({64'd0, ua} * {64'd0, ub}) >> FRAC_BITS;
         neg  = (a < 0) != (b < 0);
         if (prod[127:64] != 0 || prod[63]) begin
            ov = 1;
            return neg ? Q_MIN : Q_MAX;
         end
         return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
      endfunction

      // e^x in Q16.16 via range reduction and a Taylor polynomial in Q30
      function longint exp_q(longint x, inout bit ov);
         longint coef[8];
         longint xs, k, r, p, ln2;
         int     s;
         coef = '{213043, 1491308, 8947849, 44739243,
                  178956971, 536870912, 1073741824, 1073741824};
         ln2  = 744261118;
         if (x > (64'sd128 <<< FRAC_BITS)) x = 64'sd128 <<< FRAC_BITS;
         if (x < -(64'sd128 <<< FRAC_BITS)) x = -(64'sd128 <<< FRAC_BITS);
         xs = x * 16384;
         k  = (xs + ln2 / 2) / ln2;
         if (((xs + ln2 / 2) % ln2) != 0 && (xs + ln2 / 2) < 0) k = k - 1;
         r  = xs - k * ln2;
         p  = coef[0];
         for (int i = 1; i < 8; i++) p = coef[i] + ((p * r) >>> 30);
         s = int'(k) + FRAC_BITS - 30;
         if (s >= 0) begin
            if (s >= 62 || p > (Q_MAX >>> s)) begin
               ov = 1;
               return Q_MAX;
            end
            return p <<< s;
         end
         s = -s;
         if (s >= 62) return 0;
         return (p + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function logic [31:0] clamp_out(longint v, inout bit sat);
         if (v > 64'sd2147483647) begin
            sat = 1;
            v   = 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            sat = 1;
            v   = -64'sd2147483648;
         end
         return v[31:0];
      endfunction

      // Predict one result from an accepted pair
      function void note_pair(logic [31:0] pred_bits, logic [31:0] label_bits);
         longint       pred, lab, one, g, h, a, pf, c1, c2, e1, e2, mag;
         bit           ov, sat, bad, ignore;
         loss_result_t res;
         pred = longint'($signed(pred_bits));
         lab  = longint'($signed(label_bits));
         one  = 64'sd1 <<< FRAC_BITS;
         g = 0; h = 0; ov = 0; sat = 0; bad = 0; ignore = 0;
         case (mode_reg)
            MODE_SQUARED: begin
               g = sub_q(pred, lab, ov);
               h = one;
            end
            MODE_ABSOLUTE: begin
               g = (pred > lab) ? one : ((pred < lab) ? -one : 0);
               h = one;
            end
            MODE_HUBER: begin
               mag = (pred >= lab) ? pred - lab : lab - pred;
               if (mag <= longint'(delta_reg)) begin
                  g = sub_q(pred, lab, ov);
                  h = one;
               end else begin
                  g = (pred > lab) ? longint'(delta_reg) : -longint'(delta_reg);
                  h = 0;
               end
            end
            MODE_QUANTILE: begin
               a = longint'(alpha_reg);
               g = (lab > pred) ? -a : one - a;
               h = one;
            end
            MODE_POISSON: begin
               e1  = exp_q(pred, ov);
               bad = lab < 0;
               g   = sub_q(e1, lab, ov);
               h   = e1;
            end
            MODE_TWEEDIE: begin
               pf  = longint'(power_reg);
               c1  = one - pf;
               c2  = 2 * one - pf;
               e1  = exp_q(mul_q(c1, pred, ignore), ov);
               e2  = exp_q(mul_q(c2, pred, ignore), ov);
               bad = lab < 0;
               g   = sub_q(e2, mul_q(lab, e1, ov), ov);
               h   = add_q(mul_q(mul_q(lab, pf - one, ov), e1, ov),
                           mul_q(c2, e2, ov), ov);
               if (h < 1) h = 1;
            end
            default: ;
         endcase
         res.gradient  = clamp_out(g, sat);
         res.hessian   = clamp_out(h, sat);
         res.bad_label = bad;
         res.saturated = sat || ov;
         owed_results.push_back(res);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         fail_count++;
      endtask

      // Compare one transfer with the oldest prediction
      task check_result(logic [63:0] data, logic [1:0] flags);
         loss_result_t exp_res;
         if (owed_results.size() == 0) begin
            report($sformatf("unexpected result %h/%b", data, flags));
            return;
         end
         exp_res = owed_results.pop_front();
         if (data[31:0] !== exp_res.gradient)
            report($sformatf("gradient %h, want %h", data[31:0], exp_res.gradient));
         else if (data[63:32] !== exp_res.hessian)
            report($sformatf("hessian %h, want %h", data[63:32], exp_res.hessian));
         else if (flags[0] !== exp_res.bad_label)
            report($sformatf("bad_label %b, want %b", flags[0], exp_res.bad_label));
         else if (flags[1] !== exp_res.saturated)
            report($sformatf("saturated %b, want %b", flags[1], exp_res.saturated));
         else
            match_count++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // prediction [31:0], label [63:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // gradient [31:0], hessian [63:32]
   logic [1:0]  rsp_tuser;   // bad_label [0], saturated [1]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   loss_scoreboard sb;
   int             send_idle_pct;
   int             recv_stall_pct;
   int             holdoff_cycles;
   int             cycle_count;
   int             modes_seen;

   regression_loss_gradient_unit dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 500000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Receive side: check each transfer, then pick the next ready value
   initial begin
      rsp_tready     = 0;
      holdoff_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (holdoff_cycles > 0) begin
            holdoff_cycles--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      sb.write_reg(idx, value);
   endtask

   // Offer one pair, with random idle cycles ahead of it
   task send_pair(logic [31:0] pred, logic [31:0] lab);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {lab, pred};
      do @(posedge clock); while (!req_tready);
      sb.note_pair(pred, lab);
   endtask

   task drain();
      req_tvalid <= 0;
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   // Mixed-range Q16.16 value: full range, moderate, tiny or an extreme
   function logic [31:0] pick_value();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $urandom_range(24 << 16) - (12 << 16);
         2:       return $urandom_range(512) - 256;
         default: begin
            case ($urandom_range(3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   initial begin
      logic [31:0] pred, lab;
      int          phase;
      sb             = new();
      reset          = 1;
      req_tvalid     = 0;
      req_tdata      = 0;
      csr_psel       = 0;
      csr_penable    = 0;
      csr_pwrite     = 0;
      csr_paddr      = 0;
      csr_pwdata     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      modes_seen     = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (phase = 0; phase < 16; phase++) begin
         // Retune while idle; phases 0-7 junk the high bits to test masking
         case (phase / 8)
            0: begin
               csr_write(REG_HUBER_DELTA, (phase % 2) ? 32'hFFFF_FFFF : 32'h8000_0001);
               csr_write(REG_QUANTILE_ALPHA, (phase % 2) ? 32'hFFFF_FFFF : 32'hABCD_0001);
               csr_write(REG_TWEEDIE_POWER, (phase % 2) ? 32'hFFFF_FFFF : 32'hFFFE_0001);
            end
            default: begin
               csr_write(REG_HUBER_DELTA, $urandom_range(1, 8 << 16));
               csr_write(REG_QUANTILE_ALPHA, $urandom_range(1, 65535));
               csr_write(REG_TWEEDIE_POWER, $urandom_range(65537, 131071));
            end
         endcase
         csr_write(REG_LOSS_MODE, 32'hFFFF_FFF8 | (phase % 8));
         modes_seen++;

         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         // Hold off the receiver so the pipeline fills and backs up
         if (phase == 4) holdoff_cycles = 200;

         // Extremes and ties first
         send_pair(32'h7FFF_FFFF, 32'h8000_0000);
         send_pair(32'h8000_0000, 32'h7FFF_FFFF);
         send_pair(32'h0001_8000, 32'h0001_8000);
         send_pair(32'h0000_0000, 32'hFFFF_0000);

         for (int n = 0; n < 72; n++) begin
            pred = pick_value();
            lab  = ($urandom_range(7) == 0) ? pred : pick_value();
            send_pair(pred, lab);
         end
         // Pause the sender until every result is back
         drain();
      end

      $display("Covered %0d register phases over all eight mode codes, %0d results matched.",
               modes_seen, sb.match_count);
      $display("Included backpressure hold-off, idle and stall mixes, and extreme operands.");
      if (sb.fail_count == 0 && sb.owed_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
